@@ hw/rtl/sfr_crc8_pkg.sv @@
// shared constants and crc helper for the serial frame receiver
package sfr_crc8_pkg;

   // longest payload accepted, in bytes
   localparam int MaxPayload = 12;

   // frame header bytes and crc-8 polynomial (reflected form)
   localparam logic [7:0] HeaderFirst  = 8'h55;
   localparam logic [7:0] HeaderSecond = 8'hAA;
   localparam logic [7:0] CrcPoly      = 8'h8C;

   // payload store layout: bytes spread over lanes, one ram per lane
   localparam int LaneCount = 4;
   localparam int LaneSel   = $clog2(LaneCount);
   localparam int RowCount  = (MaxPayload + LaneCount - 1) / LaneCount;
   localparam int RowAddrW  = $clog2(RowCount);

   // crc-8 update, one byte, lsb first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // crc after both header bytes
   localparam logic [7:0] CrcAfterHeader = crc8_update(crc8_update(8'h00, HeaderFirst),
                                                       HeaderSecond);

endpackage

@@ hw/rtl/sfr_crc8_ram.sv @@
// generic single-write, single-read ram with registered read data
module sfr_crc8_ram #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/serial_frame_receiver_crc8.sv @@
// serial frame receiver: header hunt, length check, crc-8 check, payload unpacking
// after the second trailer byte a result is held pending, then moves to the output register
// throughput: one byte per cycle; the byte path stalls only while a finished
//   result waits behind a stalled output register
// payload bytes live in four lane rams; three row reads during crc and trailer
// reset (synchronous, active high) returns to header hunt with crc and counters zero
// payload bytes carry per-byte valid flags cleared at frame start, so unwritten bytes read 0
module serial_frame_receiver_crc8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_distance_bits,
   output logic [31:0] rsp_angle_bits,
   output logic [7:0]  rsp_control_flag,
   output logic [3:0]  rsp_payload_count
);
   import sfr_crc8_pkg::*;

   // receive phases, one-hot
   typedef enum logic [5:0] {
      PH_HUNT    = 6'b000001,
      PH_LEN     = 6'b000010,
      PH_PAYLOAD = 6'b000100,
      PH_CRC     = 6'b001000,
      PH_TRAIL1  = 6'b010000,
      PH_TRAIL2  = 6'b100000
   } phase_type;

   // rows of the payload store that feed the result
   localparam logic [RowAddrW-1:0] RowDistance = RowAddrW'(0);
   localparam logic [RowAddrW-1:0] RowAngle    = RowAddrW'(1);
   localparam logic [RowAddrW-1:0] RowFlag     = RowAddrW'(2);

   // control state
   phase_type             phase_ff, phase_in;
   logic [7:0]            prev_byte_ff, prev_byte_in;
   logic [3:0]            frame_len_ff, frame_len_in;
   logic [3:0]            byte_cnt_ff, byte_cnt_in;
   logic [7:0]            crc_ff, crc_in;
   logic [MaxPayload-1:0] byte_valid_ff, byte_valid_in;
   logic                  pend_ff, pend_in;
   logic [3:0]            pend_count_ff, pend_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // result assembly (no reset needed)
   logic [31:0] word_distance_ff, word_distance_in;
   logic [31:0] word_angle_ff, word_angle_in;
   logic [31:0] rsp_distance_ff, rsp_angle_ff;
   logic [7:0]  rsp_flag_ff;
   logic [3:0]  rsp_count_ff;

   // byte transaction and payload ram access
   logic                    req_accept;
   logic [4:0]              cnt_next;
   logic                    store_en;
   logic [LaneCount-1:0]    lane_wr_en;
   logic                    row_rd_en;
   logic [RowAddrW-1:0]     row_rd_addr;
   logic [8*LaneCount-1:0]  row_data;
   logic [31:0]             distance_masked, angle_masked;
   logic [7:0]              flag_masked;
   logic                    rsp_load;

   // finished result moves to the output register when it is free or draining
   assign rsp_load   = pend_ff && (!rsp_valid_ff || !rsp_stall);
   // hold bytes only while a finished result cannot leave
   assign req_stall  = pend_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign cnt_next = {1'b0, byte_cnt_ff} + 5'd1;
   assign store_en = req_accept && (phase_ff == PH_PAYLOAD)
                     && ({1'b0, byte_cnt_ff} < 5'(MaxPayload));

   // one ram per byte lane, row = byte index / lane count
   for (genvar g = 0; g < LaneCount; g++) begin : g_lane
      assign lane_wr_en[g] = store_en && (byte_cnt_ff[LaneSel-1:0] == LaneSel'(g));

      sfr_crc8_ram #(
         .Width(8),
         .Depth(RowCount)
      ) u_lane_ram (
         .clock   (clock),
         .wr_en   (lane_wr_en[g]),
         .wr_addr (byte_cnt_ff[LaneSel +: RowAddrW]),
         .wr_data (req_rx_byte),
         .rd_en   (row_rd_en),
         .rd_addr (row_rd_addr),
         .rd_data (row_data[8*g +: 8])
      );
   end

   // row reads: distance row at crc byte, angle row at first trailer, flag row at second
   always_comb begin
      row_rd_en   = 1'b0;
      row_rd_addr = RowDistance;
      if (req_accept) begin
         case (phase_ff)
            PH_CRC: begin
               row_rd_en   = 1'b1;
               row_rd_addr = RowDistance;
            end
            PH_TRAIL1: begin
               row_rd_en   = 1'b1;
               row_rd_addr = RowAngle;
            end
            PH_TRAIL2: begin
               row_rd_en   = 1'b1;
               row_rd_addr = RowFlag;
            end
            default: begin
               row_rd_en = 1'b0;
            end
         endcase
      end
   end

   // bytes never written in this frame read as zero
   always_comb begin
      for (int i = 0; i < LaneCount; i++) begin
         distance_masked[8*i +: 8] = row_data[8*i +: 8] & {8{byte_valid_ff[i]}};
         angle_masked[8*i +: 8]    = row_data[8*i +: 8] & {8{byte_valid_ff[LaneCount + i]}};
      end
      flag_masked = row_data[7:0] & {8{byte_valid_ff[2*LaneCount]}};
   end

   // phase sequencing, crc and payload bookkeeping
   always_comb begin
      phase_in         = phase_ff;
      prev_byte_in     = prev_byte_ff;
      frame_len_in     = frame_len_ff;
      byte_cnt_in      = byte_cnt_ff;
      crc_in           = crc_ff;
      byte_valid_in    = byte_valid_ff;
      pend_in          = pend_ff && !rsp_load;
      pend_count_in    = pend_count_ff;
      word_distance_in = word_distance_ff;
      word_angle_in    = word_angle_ff;

      if (store_en) begin
         byte_valid_in[byte_cnt_ff] = 1'b1;
      end

      if (req_accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (prev_byte_ff == HeaderFirst && req_rx_byte == HeaderSecond) begin
                  // frame start: payload store reads as zero from here
                  phase_in      = PH_LEN;
                  prev_byte_in  = 8'h00;
                  byte_cnt_in   = 4'd0;
                  frame_len_in  = 4'd0;
                  byte_valid_in = '0;
                  crc_in        = CrcAfterHeader;
               end else begin
                  prev_byte_in = req_rx_byte;
               end
            end
            PH_LEN: begin
               if (req_rx_byte == 8'h00 || req_rx_byte > 8'(MaxPayload)) begin
                  // bad length drops the frame
                  phase_in     = PH_HUNT;
                  prev_byte_in = 8'h00;
                  byte_cnt_in  = 4'd0;
               end else begin
                  frame_len_in = req_rx_byte[3:0];
                  crc_in       = crc8_update(crc_ff, req_rx_byte);
                  byte_cnt_in  = 4'd0;
                  phase_in     = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in      = crc8_update(crc_ff, req_rx_byte);
               byte_cnt_in = cnt_next[3:0];
               if (cnt_next >= {1'b0, frame_len_ff}) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               if (req_rx_byte != crc_ff) begin
                  // crc mismatch drops the frame, no stall
                  phase_in     = PH_HUNT;
                  prev_byte_in = 8'h00;
                  byte_cnt_in  = 4'd0;
               end else begin
                  phase_in = PH_TRAIL1;
               end
            end
            PH_TRAIL1: begin
               word_distance_in = distance_masked;
               phase_in         = PH_TRAIL2;
            end
            PH_TRAIL2: begin
               // good frame complete: flag row arrives next cycle
               word_angle_in = angle_masked;
               pend_in       = 1'b1;
               pend_count_in = frame_len_ff;
               phase_in      = PH_HUNT;
               prev_byte_in  = 8'h00;
               byte_cnt_in   = 4'd0;
               crc_in        = 8'h00;
               frame_len_in  = 4'd0;
            end
            default: begin
               phase_in     = PH_HUNT;
               prev_byte_in = 8'h00;
               byte_cnt_in  = 4'd0;
            end
         endcase
      end
   end

   // output register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         prev_byte_ff  <= 8'h00;
         frame_len_ff  <= 4'd0;
         byte_cnt_ff   <= 4'd0;
         crc_ff        <= 8'h00;
         byte_valid_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         prev_byte_ff  <= prev_byte_in;
         frame_len_ff  <= frame_len_in;
         byte_cnt_ff   <= byte_cnt_in;
         crc_ff        <= crc_in;
         byte_valid_ff <= byte_valid_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_count_ff    <= pend_count_in;
      word_distance_ff <= word_distance_in;
      word_angle_ff    <= word_angle_in;
      if (rsp_load) begin
         rsp_distance_ff <= word_distance_ff;
         rsp_angle_ff    <= word_angle_ff;
         rsp_flag_ff     <= flag_masked;
         rsp_count_ff    <= pend_count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance_bits = rsp_distance_ff;
   assign rsp_angle_bits    = rsp_angle_ff;
   assign rsp_control_flag  = rsp_flag_ff;
   assign rsp_payload_count = rsp_count_ff;

endmodule
